/* src/fbe_pkg.sv */
package fbe_pkg;

    // input transaction function codes
    localparam logic [1:0] FN_WRITE   = 2'd0;
    localparam logic [1:0] FN_FILL    = 2'd1;
    localparam logic [1:0] FN_RESTART = 2'd2;
    localparam logic [1:0] FN_FETCH   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_SCALE  = 2'd2;

    // configuration reset values
    localparam logic [7:0] RST_WIDTH  = 8'd128;
    localparam logic [7:0] RST_HEIGHT = 8'd128;
    localparam logic [3:0] RST_SCALE  = 4'd1;

    // pixel byte order within one pixel
    localparam logic [1:0] PH_BLUE  = 2'd0;
    localparam logic [1:0] PH_GREEN = 2'd1;
    localparam logic [1:0] PH_RED   = 2'd2;

    // bmp header constants
    localparam logic [5:0]  HDR_LEN    = 6'd54;
    localparam logic [31:0] HDR_LEN32  = 32'd54;
    localparam logic [31:0] DIB_LEN    = 32'd40;
    localparam logic [31:0] PIX_PER_M  = 32'd2835;
    localparam logic [15:0] BITS_PER_PX = 16'd24;
    localparam logic [15:0] PLANES     = 16'd1;
    localparam logic [7:0]  CH_B       = 8'h42;
    localparam logic [7:0]  CH_M       = 8'h4D;

    // header byte at a position; from byte 2 on the fields are packed into 32-bit words
    function automatic logic [7:0] hdr_byte(input logic [5:0] pos, input logic [31:0] pds,
                                            input logic [31:0] ow, input logic [31:0] oh);
        logic [5:0]  sub;
        logic [31:0] word;
        logic [7:0]  b;
        sub = pos - 6'd2;
        unique case (sub[5:2])
            4'd0:    word = pds + HDR_LEN32;
            4'd2:    word = HDR_LEN32;
            4'd3:    word = DIB_LEN;
            4'd4:    word = ow;
            4'd5:    word = oh;
            4'd6:    word = {BITS_PER_PX, PLANES};
            4'd8:    word = pds;
            4'd9:    word = PIX_PER_M;
            4'd10:   word = PIX_PER_M;
            default: word = 32'd0;
        endcase
        unique case (sub[1:0])
            2'd0:    b = word[7:0];
            2'd1:    b = word[15:8];
            2'd2:    b = word[23:16];
            default: b = word[31:24];
        endcase
        if (pos == 6'd0) begin
            b = CH_B;
        end else if (pos == 6'd1) begin
            b = CH_M;
        end
        return b;
    endfunction

    // rgb565 channel expanded to eight bits by bit replication
    function automatic logic [7:0] pix_byte(input logic [15:0] c, input logic [1:0] phase);
        logic [7:0] b;
        unique case (phase)
            PH_BLUE:  b = {c[4:0], c[4:2]};
            PH_GREEN: b = {c[10:5], c[10:9]};
            default:  b = {c[15:11], c[15:13]};
        endcase
        return b;
    endfunction

endpackage

/* src/fbe_in_if.sv */
interface fbe_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]       pixel_color;

    modport source (output valid, output func, output pos_x, output pos_y,
                    output pixel_color, input ready);
    modport sink   (input valid, input func, input pos_x, input pos_y,
                    input pixel_color, output ready);
endinterface

/* src/fbe_out_if.sv */
interface fbe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] bmp_byte;
    logic       last_byte;

    modport source (output valid, output bmp_byte, output last_byte, input ready);
    modport sink   (input valid, input bmp_byte, input last_byte, output ready);
endinterface

/* src/framebuffer_bmp_stream_encoder_unit.sv */
// channel   dir  handshake      payload
// i_in      in   valid/ready    func, pos_x, pos_y, pixel_color
// o_out     out  valid/ready    bmp_byte, last_byte
// i_cfg_*   in   write enable   i_cfg_idx, i_cfg_data
//
// after reset a clearing pass zeroes every entry of the frame store
// pixel write: the address multiply then the store write; a clipped write is dropped
// fill: the shared multiplier forms width*height, then one store entry per cycle
// restart: the header sizes pass through the shared multiplier
// fetch: the registered store read then the output register load;
// with no readout running no byte is produced
// a fetch waits while the output register still holds an untaken byte

module framebuffer_bmp_stream_encoder_unit #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128,
    parameter int MAX_SCALE  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    fbe_in_if.sink      i_in,
    fbe_out_if.source   o_out
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int W_W    = $clog2(MAX_WIDTH + 1);
    localparam int H_W    = $clog2(MAX_HEIGHT + 1);
    localparam int S_W    = $clog2(MAX_SCALE + 1);
    localparam int OW_W   = $clog2(MAX_WIDTH * MAX_SCALE + 1);
    localparam int OH_W   = $clog2(MAX_HEIGHT * MAX_SCALE + 1);
    localparam int RBC_W  = $clog2(3 * MAX_WIDTH * MAX_SCALE + 4);
    localparam int PDS_W  = RBC_W + OH_W;

    typedef enum logic [8:0] {
        S_CLR   = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_WR    = 9'b000000100,
        S_FILL  = 9'b000001000,
        S_ROW   = 9'b000010000,
        S_ROH   = 9'b000100000,
        S_RBASE = 9'b001000000,
        S_RPDS  = 9'b010000000,
        S_FOUT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0] r_pw, r_ph;
    logic [3:0] r_ps;
    logic r_active, n_active;
    logic [5:0] r_hpos, n_hpos;
    logic [OH_W-1:0] r_row, n_row;
    logic [OW_W-1:0] r_col, n_col;
    logic [1:0] r_phase, n_phase;
    logic [1:0] r_pad, n_pad;
    logic [1:0] r_pad_tot, n_pad_tot;
    logic [RBC_W-1:0] r_rbc, n_rbc;
    logic [PDS_W-1:0] r_pds, n_pds;
    logic [OW_W-1:0] r_ow, n_ow;
    logic [OH_W-1:0] r_oh, n_oh;
    logic [W_W-1:0] r_lw, n_lw;
    logic [H_W-1:0] r_lh, n_lh;
    logic [S_W-1:0] r_ls, n_ls;
    logic [IDX_W-1:0] r_base, n_base;
    logic [W_W-1:0] r_sx, n_sx;
    logic [S_W-1:0] r_rx, n_rx;
    logic [S_W-1:0] r_ry, n_ry;
    logic [W_W-1:0] r_wx, n_wx;
    logic [15:0] r_color, n_color;
    logic r_ov, n_ov;
    logic [7:0] r_ob, n_ob;
    logic r_ol, n_ol;

    logic [W_W-1:0] eff_w;
    logic [H_W-1:0] eff_h;
    logic [S_W-1:0] eff_s;
    logic in_acc;
    logic wr_ok;
    logic [15:0] x_u, y_u;
    logic mul_en;
    logic [RBC_W-1:0] mul_a;
    logic [OH_W-1:0] mul_b;
    logic [PDS_W-1:0] mul_p;
    logic mem_we, mem_re;
    logic [IDX_W-1:0] mem_waddr;
    logic [15:0] mem_wdata;
    logic [15:0] mem_rdata;
    logic [RBC_W-1:0] ow3p3;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw <= fbe_pkg::RST_WIDTH;
            r_ph <= fbe_pkg::RST_HEIGHT;
            r_ps <= fbe_pkg::RST_SCALE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fbe_pkg::CFG_WIDTH:  r_pw <= i_cfg_data;
                fbe_pkg::CFG_HEIGHT: r_ph <= i_cfg_data;
                fbe_pkg::CFG_SCALE:  r_ps <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // registers clamped into their legal ranges
    always_comb begin
        if (r_pw == 8'd0) begin
            eff_w = W_W'(1);
        end else if (r_pw > MAX_WIDTH) begin
            eff_w = W_W'(MAX_WIDTH);
        end else begin
            eff_w = W_W'(r_pw);
        end
        if (r_ph == 8'd0) begin
            eff_h = H_W'(1);
        end else if (r_ph > MAX_HEIGHT) begin
            eff_h = H_W'(MAX_HEIGHT);
        end else begin
            eff_h = H_W'(r_ph);
        end
        if (r_ps == 4'd0) begin
            eff_s = S_W'(1);
        end else if (r_ps > MAX_SCALE) begin
            eff_s = S_W'(MAX_SCALE);
        end else begin
            eff_s = S_W'(r_ps);
        end
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc = i_in.valid && i_in.ready;
    assign x_u = i_in.pos_x;
    assign y_u = i_in.pos_y;
    assign wr_ok = !x_u[15] && !y_u[15] && (x_u < 16'(eff_w)) && (y_u < 16'(eff_h));

    // row size in bytes plus three, ahead of the rounding up to four bytes
    assign ow3p3 = (RBC_W'(r_ow) << 1) + RBC_W'(r_ow) + RBC_W'(3);

    // shared multiplier operand selection
    always_comb begin
        mul_en = 1'b0;
        mul_a  = RBC_W'(eff_w);
        mul_b  = OH_W'(y_u);
        unique case (r_state)
            S_IDLE: begin
                mul_en = in_acc;
                if (i_in.func == fbe_pkg::FN_FILL) begin
                    mul_b = OH_W'(eff_h);
                end else if (i_in.func == fbe_pkg::FN_RESTART) begin
                    mul_b = OH_W'(eff_s);
                end
            end
            S_ROW: begin
                mul_en = 1'b1;
                mul_a  = RBC_W'(r_ls);
                mul_b  = OH_W'(r_lh);
            end
            S_ROH: begin
                mul_en = 1'b1;
                mul_a  = RBC_W'(r_lw);
                mul_b  = OH_W'(r_lh - H_W'(1));
            end
            S_RBASE: begin
                mul_en = 1'b1;
                mul_a  = r_rbc;
                mul_b  = r_oh;
            end
            default: ;
        endcase
    end

    fbe_mul #(
        .A_W (RBC_W),
        .B_W (OH_W)
    ) u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // store write port: clearing pass, fill sweep or a single pixel
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_cnt[IDX_W-1:0];
        mem_wdata = 16'd0;
        unique case (r_state)
            S_CLR: begin
                mem_we = 1'b1;
            end
            S_FILL: begin
                mem_we    = 1'b1;
                mem_wdata = r_color;
            end
            S_WR: begin
                mem_we    = 1'b1;
                mem_waddr = mul_p[IDX_W-1:0] + IDX_W'(r_wx);
                mem_wdata = r_color;
            end
            default: ;
        endcase
    end

    assign mem_re = in_acc && (i_in.func == fbe_pkg::FN_FETCH);

    fbe_frame_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_base + IDX_W'(r_sx)),
        .o_rdata (mem_rdata)
    );

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_active  = r_active;
        n_hpos    = r_hpos;
        n_row     = r_row;
        n_col     = r_col;
        n_phase   = r_phase;
        n_pad     = r_pad;
        n_pad_tot = r_pad_tot;
        n_rbc     = r_rbc;
        n_pds     = r_pds;
        n_ow      = r_ow;
        n_oh      = r_oh;
        n_lw      = r_lw;
        n_lh      = r_lh;
        n_ls      = r_ls;
        n_base    = r_base;
        n_sx      = r_sx;
        n_rx      = r_rx;
        n_ry      = r_ry;
        n_wx      = r_wx;
        n_color   = r_color;
        n_ob      = r_ob;
        n_ol      = r_ol;
        n_ov      = r_ov;

        // output transaction taken
        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_CLR: begin
                if (r_cnt == CNT_W'(DEPTH - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_color = i_in.pixel_color;
                    n_wx    = W_W'(x_u);
                    n_cnt   = '0;
                    unique case (i_in.func)
                        fbe_pkg::FN_WRITE: begin
                            if (wr_ok) begin
                                n_state = S_WR;
                            end
                        end
                        fbe_pkg::FN_FILL: begin
                            n_state = S_FILL;
                        end
                        fbe_pkg::FN_RESTART: begin
                            n_lw    = eff_w;
                            n_lh    = eff_h;
                            n_ls    = eff_s;
                            n_state = S_ROW;
                        end
                        default: begin
                            if (r_active) begin
                                n_state = S_FOUT;
                            end
                        end
                    endcase
                end
            end
            S_WR: begin
                n_state = S_IDLE;
            end
            S_FILL: begin
                if (r_cnt + CNT_W'(1) == mul_p[CNT_W-1:0]) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_ROW: begin
                n_ow    = OW_W'(mul_p);
                n_state = S_ROH;
            end
            S_ROH: begin
                n_oh      = OH_W'(mul_p);
                n_rbc     = ow3p3 & ~RBC_W'(3);
                n_pad_tot = 2'(n_rbc - (ow3p3 - RBC_W'(3)));
                n_state   = S_RBASE;
            end
            S_RBASE: begin
                n_base  = mul_p[IDX_W-1:0];
                n_state = S_RPDS;
            end
            S_RPDS: begin
                n_pds    = mul_p;
                n_active = 1'b1;
                n_hpos   = '0;
                n_row    = '0;
                n_col    = '0;
                n_phase  = fbe_pkg::PH_BLUE;
                n_pad    = r_pad_tot;
                n_sx     = '0;
                n_rx     = '0;
                n_ry     = r_ls - S_W'(1);
                n_state  = S_IDLE;
            end
            S_FOUT: begin
                if (!r_ov || o_out.ready) begin
                    n_ov    = 1'b1;
                    n_ol    = 1'b0;
                    n_state = S_IDLE;
                    if (r_hpos < fbe_pkg::HDR_LEN) begin
                        n_ob   = fbe_pkg::hdr_byte(r_hpos, 32'(r_pds), 32'(r_ow), 32'(r_oh));
                        n_hpos = r_hpos + 6'd1;
                    end else begin
                        // pixel bytes, then row padding
                        if (r_col < r_ow) begin
                            n_ob = fbe_pkg::pix_byte(mem_rdata, r_phase);
                            if (r_phase == fbe_pkg::PH_RED) begin
                                n_phase = fbe_pkg::PH_BLUE;
                                n_col   = r_col + OW_W'(1);
                                if (r_rx == r_ls - S_W'(1)) begin
                                    n_rx = '0;
                                    n_sx = r_sx + W_W'(1);
                                end else begin
                                    n_rx = r_rx + S_W'(1);
                                end
                            end else begin
                                n_phase = r_phase + 2'd1;
                            end
                        end else begin
                            n_ob = 8'd0;
                            if (r_pad != 2'd0) begin
                                n_pad = r_pad - 2'd1;
                            end
                        end
                        // end of an output row: step up one source row when due
                        if (n_col >= r_ow && n_pad == 2'd0) begin
                            n_row   = r_row + OH_W'(1);
                            n_col   = '0;
                            n_phase = fbe_pkg::PH_BLUE;
                            n_pad   = r_pad_tot;
                            n_sx    = '0;
                            n_rx    = '0;
                            if (r_ry == '0) begin
                                n_ry   = r_ls - S_W'(1);
                                n_base = r_base - IDX_W'(r_lw);
                            end else begin
                                n_ry = r_ry - S_W'(1);
                            end
                            if (n_row >= r_oh) begin
                                n_ol     = 1'b1;
                                n_active = 1'b0;
                            end
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_cnt    <= '0;
            r_active <= 1'b0;
            r_hpos   <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_phase  <= fbe_pkg::PH_BLUE;
            r_pad    <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_active <= n_active;
            r_hpos   <= n_hpos;
            r_row    <= n_row;
            r_col    <= n_col;
            r_phase  <= n_phase;
            r_pad    <= n_pad;
            r_ov     <= n_ov;
        end
    end

    // latched readout geometry and payload
    always_ff @(posedge i_clk) begin
        r_pad_tot <= n_pad_tot;
        r_rbc     <= n_rbc;
        r_pds     <= n_pds;
        r_ow      <= n_ow;
        r_oh      <= n_oh;
        r_lw      <= n_lw;
        r_lh      <= n_lh;
        r_ls      <= n_ls;
        r_base    <= n_base;
        r_sx      <= n_sx;
        r_rx      <= n_rx;
        r_ry      <= n_ry;
        r_wx      <= n_wx;
        r_color   <= n_color;
        r_ob      <= n_ob;
        r_ol      <= n_ol;
    end

    assign o_out.valid     = r_ov;
    assign o_out.bmp_byte  = r_ob;
    assign o_out.last_byte = r_ol;

endmodule

/* src/fbe_mul.sv */
module fbe_mul #(
    parameter int A_W = 16,
    parameter int B_W = 15
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [A_W-1:0]       i_a,
    input  logic [B_W-1:0]       i_b,
    output logic [A_W+B_W-1:0]   o_p
);

    logic [A_W+B_W-1:0] r_p;

    // shared multiplier, product registered and held while disabled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= (A_W+B_W)'(i_a) * (A_W+B_W)'(i_b);
        end
    end

    assign o_p = r_p;

endmodule

/* src/fbe_frame_mem.sv */
module fbe_frame_mem #(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [15:0]       i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [15:0]       o_rdata
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/fbe_checker.sv */
module fbe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_in_func,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    // a waiting output transaction stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output transaction dropped while stalled");

    // a stalled output payload holds
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_byte) && $stable(i_out_last))
        else $error("output payload changed while stalled");

    // restart keeps the input side busy for the header setup
    a_restart_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_func == fbe_pkg::FN_RESTART)
        |=> !i_in_ready ##1 !i_in_ready)
        else $error("input accepted during restart setup");

    // a new byte is only loaded while the input side is busy with a fetch
    a_out_from_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("output appeared without a fetch in progress");

    // reset starts the clearing pass
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input ready right after reset");

endmodule

bind framebuffer_bmp_stream_encoder_unit fbe_checker u_fbe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_func   (i_in.func),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.bmp_byte),
    .i_out_last  (o_out.last_byte)
);

/* tb/framebuffer_bmp_stream_encoder_unit_tb.sv */
module framebuffer_bmp_stream_encoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB_W         = 128;
    localparam int FB_H         = 128;
    localparam int FB_SCALE     = 8;
    localparam int FB_CELLS     = FB_W * FB_H;
    localparam int HDR_BYTES    = 54;
    localparam int TARGET_ITEMS = 1250;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 16;

    typedef struct {
        logic [1:0]         fn;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        color;
    } t_pixel_cmd;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_bmp_beat;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [7:0] i_cfg_data;

    fbe_in_if  in_if ();
    fbe_out_if out_if ();

    framebuffer_bmp_stream_encoder_unit #(
        .MAX_WIDTH  (FB_W),
        .MAX_HEIGHT (FB_H),
        .MAX_SCALE  (FB_SCALE)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // frame store and readout state of the predictor
    logic [15:0]  fb_mem [FB_CELLS];
    logic [7:0]   reg_w;
    logic [7:0]   reg_h;
    logic [3:0]   reg_s;
    bit           file_open;
    int unsigned  hdr_idx, out_row, out_col, pad_rem, pad_all;
    int unsigned  row_bytes, data_bytes, file_w, file_scale, file_ow, file_oh;
    logic [1:0]   pix_phase;
    logic [7:0]   hdr_bytes [HDR_BYTES];

    // transaction queues and bookkeeping
    t_pixel_cmd   pending_cmds [$];
    t_bmp_beat    bmp_expected [$];
    t_pixel_cmd   next_cmd;
    t_pixel_cmd   taken_cmd;
    t_bmp_beat    want;
    int           queued_items;
    int           accepted_items;
    int           fill_backlog;
    int           mismatches;
    bit           in_taken;
    int           in_gap, in_burst;
    int           out_gap, out_burst, out_hold;
    int           hold_req, hold_ack;

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned eff_w();
        return clamp_dim(reg_w, FB_W);
    endfunction

    function automatic int unsigned eff_h();
        return clamp_dim(reg_h, FB_H);
    endfunction

    function automatic int unsigned eff_scale();
        return clamp_dim(reg_s, FB_SCALE);
    endfunction

    // total bytes of the file the current setting would produce
    function automatic int unsigned file_length();
        int unsigned ow;
        int unsigned rb;
        ow = eff_w() * eff_scale();
        rb = ((ow * 3 + 3) / 4) * 4;
        return HDR_BYTES + rb * eff_h() * eff_scale();
    endfunction

    function automatic void put_word(int pos, logic [31:0] v, int n);
        for (int i = 0; i < n; i++) begin
            hdr_bytes[pos + i] = v[8 * i +: 8];
        end
    endfunction

    // rgb565 channel widened to eight bits by repeating its top bits
    function automatic logic [7:0] channel_byte(logic [15:0] c, logic [1:0] ph);
        case (ph)
            fbe_pkg::PH_BLUE:  return {c[4:0], c[4:2]};
            fbe_pkg::PH_GREEN: return {c[10:5], c[10:9]};
            default:           return {c[15:11], c[15:13]};
        endcase
    endfunction

    // latch the geometry and build the header
    function automatic void open_file();
        file_w     = eff_w();
        file_scale = eff_scale();
        file_ow    = file_w * file_scale;
        file_oh    = eff_h() * file_scale;
        row_bytes  = ((file_ow * 3 + 3) / 4) * 4;
        pad_all    = row_bytes - file_ow * 3;
        data_bytes = row_bytes * file_oh;
        for (int i = 0; i < HDR_BYTES; i++) begin
            hdr_bytes[i] = 8'h00;
        end
        hdr_bytes[0] = "B";
        hdr_bytes[1] = "M";
        put_word(2, HDR_BYTES + data_bytes, 4);
        put_word(10, HDR_BYTES, 4);
        put_word(14, 40, 4);
        put_word(18, file_ow, 4);
        put_word(22, file_oh, 4);
        put_word(26, 1, 2);
        put_word(28, 24, 2);
        put_word(34, data_bytes, 4);
        put_word(38, 2835, 4);
        put_word(42, 2835, 4);
        file_open = 1'b1;
        hdr_idx   = 0;
        out_row   = 0;
        out_col   = 0;
        pix_phase = fbe_pkg::PH_BLUE;
        pad_rem   = pad_all;
    endfunction

    // apply one accepted transaction, queue the byte it yields if any
    function automatic void bmp_model_step(t_pixel_cmd cmd);
        int          xi;
        int          yi;
        int unsigned w;
        int unsigned h;
        int unsigned sx;
        int unsigned sy;
        logic [7:0]  b;
        logic        last;
        w    = eff_w();
        h    = eff_h();
        xi   = 32'(cmd.x);
        yi   = 32'(cmd.y);
        last = 1'b0;
        case (cmd.fn)
            fbe_pkg::FN_WRITE: begin
                if (xi >= 0 && yi >= 0 && xi < int'(w) && yi < int'(h)) begin
                    fb_mem[yi * w + xi] = cmd.color;
                end
            end
            fbe_pkg::FN_FILL: begin
                for (int i = 0; i < w * h; i++) begin
                    fb_mem[i] = cmd.color;
                end
            end
            fbe_pkg::FN_RESTART: begin
                open_file();
            end
            default: begin
                if (!file_open) return;
                if (hdr_idx < HDR_BYTES) begin
                    b = hdr_bytes[hdr_idx];
                    hdr_idx++;
                end else begin
                    if (out_col < file_ow) begin
                        sy = (file_oh - 1 - out_row) / file_scale;
                        sx = out_col / file_scale;
                        b  = channel_byte(fb_mem[sy * file_w + sx], pix_phase);
                        if (pix_phase == fbe_pkg::PH_RED) begin
                            pix_phase = fbe_pkg::PH_BLUE;
                            out_col++;
                        end else begin
                            pix_phase++;
                        end
                    end else begin
                        b = 8'h00;
                        if (pad_rem > 0) pad_rem--;
                    end
                    // row done once pixels and padding are out
                    if (out_col >= file_ow && pad_rem == 0) begin
                        out_row++;
                        out_col   = 0;
                        pix_phase = fbe_pkg::PH_BLUE;
                        pad_rem   = pad_all;
                        if (out_row >= file_oh) begin
                            last      = 1'b1;
                            file_open = 1'b0;
                        end
                    end
                end
                bmp_expected.push_back('{data: b, last: last});
            end
        endcase
    endfunction

    // mostly short gaps, a few long ones
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #100ms;
        $display("Some tests failed");
        $finish;
    end

    // input transaction accept and prediction
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && in_if.valid && in_if.ready;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            taken_cmd.fn    = in_if.func;
            taken_cmd.x     = in_if.pos_x;
            taken_cmd.y     = in_if.pos_y;
            taken_cmd.color = in_if.pixel_color;
            bmp_model_step(taken_cmd);
            accepted_items++;
        end
    end

    // input driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_taken) begin
                if (in_burst > 0) begin
                    in_burst--;
                    in_gap = 0;
                end else begin
                    in_gap = draw_gap();
                    if ($urandom_range(0, 29) == 0) in_burst = $urandom_range(20, 80);
                end
            end
            if (!in_if.valid || in_taken) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_if.valid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    next_cmd = pending_cmds.pop_front();
                    in_if.valid       <= 1'b1;
                    in_if.func        <= next_cmd.fn;
                    in_if.pos_x       <= next_cmd.x;
                    in_if.pos_y       <= next_cmd.y;
                    in_if.pixel_color <= next_cmd.color;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // output ready: random stalls plus requested long holds
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_ack != hold_req) begin
                hold_ack = hold_req;
                out_hold = HOLD_CYCLES;
            end
            if (out_hold > 0) begin
                out_hold--;
                out_if.ready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                if (out_burst > 0) begin
                    out_burst--;
                end else if ($urandom_range(0, 3) == 0) begin
                    out_gap = draw_gap();
                    if ($urandom_range(0, 19) == 0) out_burst = $urandom_range(30, 120);
                end
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (bmp_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected byte %02h last %0b", out_if.bmp_byte, out_if.last_byte);
                end
            end else begin
                want = bmp_expected.pop_front();
                if (want.data !== out_if.bmp_byte || want.last !== out_if.last_byte) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                                 want.data, want.last, out_if.bmp_byte, out_if.last_byte);
                    end
                end
            end
        end
    end

    task automatic push_cmd(logic [1:0] fn, logic signed [15:0] x, logic signed [15:0] y,
                            logic [15:0] color);
        pending_cmds.push_back('{fn: fn, x: x, y: y, color: color});
        queued_items++;
        if (fn == fbe_pkg::FN_FILL) fill_backlog += eff_w() * eff_h();
    endtask

    task automatic push_fetches(int n);
        for (int i = 0; i < n; i++) begin
            push_cmd(fbe_pkg::FN_FETCH, 16'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    task automatic push_pixel_writes(int n);
        logic signed [15:0] x;
        logic signed [15:0] y;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                x = 16'($urandom);
                y = 16'($urandom);
            end else begin
                x = 16'($urandom_range(0, eff_w()));
                y = 16'($urandom_range(0, eff_h()));
            end
            push_cmd(fbe_pkg::FN_WRITE, x, y, 16'($urandom));
        end
    endtask

    // sender pauses until every transaction is taken and every byte is out
    task automatic drain();
        while (accepted_items != queued_items || bmp_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE + fill_backlog) @(posedge i_clk);
        fill_backlog = 0;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            fbe_pkg::CFG_WIDTH:  reg_w = val;
            fbe_pkg::CFG_HEIGHT: reg_h = val;
            default:             reg_s = val[3:0];
        endcase
    endtask

    task automatic set_size(logic [7:0] w, logic [7:0] h, logic [3:0] s);
        write_reg(fbe_pkg::CFG_WIDTH, w);
        write_reg(fbe_pkg::CFG_HEIGHT, h);
        write_reg(fbe_pkg::CFG_SCALE, {4'd0, s});
    endtask

    // mostly small panels so files finish, now and then extremes
    task automatic pick_setting();
        logic [7:0] w;
        logic [7:0] h;
        logic [3:0] s;
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0:       w = 8'd0;
                1:       w = 8'd128;
                2:       w = 8'($urandom_range(129, 255));
                default: w = 8'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       h = 8'd0;
                1:       h = 8'd128;
                2:       h = 8'($urandom_range(129, 255));
                default: h = 8'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       s = 4'd0;
                1:       s = 4'd8;
                2:       s = 4'($urandom_range(9, 15));
                default: s = 4'($urandom);
            endcase
        end else begin
            w = 8'($urandom_range(1, 4));
            h = 8'($urandom_range(1, 3));
            s = ($urandom_range(0, 3) == 0) ? 4'd3 : 4'($urandom_range(1, 2));
        end
        set_size(w, h, s);
    endtask

    // new setting, optional fill, pixel writes, restart, then read the file or, if long, its start
    task automatic run_phase(bit long_hold);
        int  len;
        int  mid;
        bit  restarted;
        bit  reconfig;
        drain();
        pick_setting();
        if ($urandom_range(0, 3) == 0) begin
            push_cmd(fbe_pkg::FN_FILL, 16'($urandom), 16'($urandom), 16'($urandom));
        end
        push_pixel_writes($urandom_range(0, 8));
        push_cmd(fbe_pkg::FN_RESTART, 16'($urandom), 16'($urandom), 16'($urandom));
        len = file_length();
        if (len > 400) begin
            len = HDR_BYTES + $urandom_range(0, 120);
        end else begin
            len += $urandom_range(0, 2);
        end
        mid       = len / 2;
        restarted = 1'b0;
        reconfig  = ($urandom_range(0, 5) == 0);
        if (long_hold) hold_req++;
        for (int i = 0; i < len; i++) begin
            push_fetches(1);
            if ($urandom_range(0, 29) == 0) push_pixel_writes(1);
            if (!restarted && $urandom_range(0, 199) == 0) begin
                // restart in the middle: the file starts over
                push_cmd(fbe_pkg::FN_RESTART, 16'($urandom), 16'($urandom), 16'($urandom));
                restarted = 1'b1;
                i = 0;
            end
            // new setting while the readout is still running
            if (reconfig && i == mid) begin
                drain();
                pick_setting();
            end
        end
    endtask

    task automatic noise_phase();
        repeat ($urandom_range(5, 15)) begin
            push_cmd(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        int phase_no;
        in_if.valid       = 1'b0;
        in_if.func        = fbe_pkg::FN_WRITE;
        in_if.pos_x       = '0;
        in_if.pos_y       = '0;
        in_if.pixel_color = '0;
        out_if.ready      = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = fbe_pkg::CFG_WIDTH;
        i_cfg_data        = '0;
        i_rst_n           = 1'b0;
        for (int i = 0; i < FB_CELLS; i++) begin
            fb_mem[i] = 16'h0000;
        end
        reg_w     = fbe_pkg::RST_WIDTH;
        reg_h     = fbe_pkg::RST_HEIGHT;
        reg_s     = fbe_pkg::RST_SCALE;
        file_open = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset size: fetch with no readout, clipped and corner writes
        push_fetches(1);
        push_cmd(fbe_pkg::FN_WRITE, 16'sd0, 16'sd0, 16'hFFFF);
        push_cmd(fbe_pkg::FN_WRITE, 16'sd127, 16'sd127, 16'h8421);
        push_cmd(fbe_pkg::FN_WRITE, 16'sd128, 16'sd0, 16'h1234);
        push_cmd(fbe_pkg::FN_WRITE, 16'sd0, 16'sd128, 16'h5678);
        push_cmd(fbe_pkg::FN_WRITE, -16'sd1, 16'sd5, 16'h9ABC);
        push_cmd(fbe_pkg::FN_WRITE, 16'sd5, -16'sd32768, 16'hDEF0);
        push_cmd(fbe_pkg::FN_WRITE, 16'sd32767, 16'sd32767, 16'h0F0F);
        push_cmd(fbe_pkg::FN_RESTART, 16'sd0, 16'sd0, 16'h0000);
        push_fetches(3);
        push_cmd(fbe_pkg::FN_RESTART, 16'sd0, 16'sd0, 16'h0000);
        push_fetches(2);

        // smallest panel via zero registers, whole file plus one fetch past the end
        drain();
        set_size(8'd0, 8'd0, 4'd0);
        push_cmd(fbe_pkg::FN_WRITE, 16'sd0, 16'sd0, 16'hF81F);
        push_cmd(fbe_pkg::FN_RESTART, 16'sd0, 16'sd0, 16'h0000);
        push_fetches(file_length() + 1);

        // largest panel and scale, full fill, header and first pixels
        drain();
        set_size(8'd255, 8'd128, 4'd15);
        push_cmd(fbe_pkg::FN_FILL, 16'sd0, 16'sd0, 16'hA5C3);
        push_cmd(fbe_pkg::FN_WRITE, 16'sd0, 16'sd127, 16'h07E0);
        push_cmd(fbe_pkg::FN_RESTART, 16'sd0, 16'sd0, 16'h0000);
        push_fetches(HDR_BYTES + 30);

        phase_no = 0;
        while (queued_items < TARGET_ITEMS) begin
            phase_no++;
            if (phase_no != 3 && $urandom_range(0, 9) == 0) begin
                noise_phase();
            end else begin
                run_phase(phase_no == 3 || phase_no % 20 == 10);
            end
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
